### hw/rtl/integer_to_ascii_formatter_assert.svh
// Assertion macros for the integer to ASCII formatter.
// Each macro checks an implication on the rising clock edge and is
// switched off while reset is high.
`ifndef INTEGER_TO_ASCII_FORMATTER_ASSERT_SVH
`define INTEGER_TO_ASCII_FORMATTER_ASSERT_SVH
`ifndef ASSERT_OFF
`define I2A_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("integer_to_ascii_formatter: same-cycle check failed");
`define I2A_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("integer_to_ascii_formatter: next-cycle check failed");
`else
`define I2A_ASSERT_IMPL(lbl, ante, cons)
`define I2A_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### hw/rtl/i2a_pkg.sv
package i2a_pkg;

   // Sizes of the formatter.
   localparam int VALUE_BITS    = 32;
   localparam int MAX_WIDTH     = 64;
   localparam int MAX_PRECISION = 40;

   // Octal needs the most digits; decimal needs at most this many.
   localparam int NUM_DIGITS = (VALUE_BITS + 2) / 3;
   localparam int DEC_DIGITS = (VALUE_BITS * 3 + 9) / 10;

   localparam int DIG_IDX_W = $clog2(NUM_DIGITS);
   localparam int ND_W      = $clog2(NUM_DIGITS + 1);
   localparam int CNT_W     = $clog2(MAX_PRECISION + 1);
   localparam int LEN_W     = 7;
   localparam int BIT_CNT_W = $clog2(VALUE_BITS);
   localparam int REQ_DATA_W = 56;

   // Base selector and plus mode codes.
   localparam logic [1:0] BSEL_OCT   = 2'd0;
   localparam logic [1:0] BSEL_DEC   = 2'd1;
   localparam logic [1:0] PLUS_NONE  = 2'd0;
   localparam logic [1:0] PLUS_SPACE = 2'd1;
   localparam logic [1:0] PLUS_PLUS  = 2'd2;

   localparam logic [3:0] DEC_RADIX = 4'd10;

   // Characters.
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_MINUS   = 8'h2D;
   localparam logic [7:0] CHAR_APOS    = 8'h27;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_LOWER_X = 8'h78;
   localparam logic [7:0] CHAR_UPPER_X = 8'h58;

   typedef logic [3:0] digit_type;

   typedef enum logic [1:0] {
      BASE_OCT,
      BASE_DEC,
      BASE_HEX
   } base_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CONV,
      S_SCAN,
      S_SIZE,
      S_TOTAL,
      S_PLAN,
      S_PADL,
      S_SIGN,
      S_PFX0,
      S_PFXX,
      S_ZPAD,
      S_DIGIT,
      S_SEP,
      S_PADR
   } state_type;

   // Division by three through a reciprocal; exact for inputs below 512.
   function automatic logic [CNT_W-1:0] div3(input logic [CNT_W-1:0] x);
      logic [CNT_W+8:0] p;
      p = (CNT_W + 9)'(x) * (CNT_W + 9)'(171);
      return CNT_W'(p[CNT_W+8:9]);
   endfunction

   // ASCII character of one digit.
   function automatic logic [7:0] digit_char(input digit_type d, input logic up);
      logic [7:0] ch;
      if (d < DEC_RADIX) begin
         ch = CHAR_ZERO + 8'(d);
      end else begin
         ch = (up ? CHAR_UPPER_A : CHAR_LOWER_A) + 8'(d) - 8'(DEC_RADIX);
      end
      return ch;
   endfunction

endpackage

### hw/rtl/integer_to_ascii_formatter.sv
// Integer to ASCII formatter. Each accepted request word carries one integer and its
// printf-style options; the block answers with the formatted text, one character per
// response word, with tlast set on the final character (a zero with precision and width
// zero, no sign and no octal alternate form gives no words at all). One request is
// handled at a time. Octal and hex digits are taken straight from the magnitude; decimal
// digits come from a shift-and-add-3 converter that takes the value bits in turn, most
// significant first. After that the scan, size and total states size the field, the
// plan state picks the first section, and then one character leaves per cycle while
// the response side takes them. The next request is taken as soon as the last
// character sits in the output register.
`include "integer_to_ascii_formatter_assert.svh"

module integer_to_ascii_formatter
   import i2a_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // value[31:0], base_sel[33:32], upper[34], alternate[35], group_digits[36],
   // zero_pad[37], left_adjust[38], plus_mode[40:39], min_width[47:41],
   // precision[54:48], zero[55]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // is_signed[0]
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // out_char[7:0]
   output logic [7:0]            rsp_tdata,
   output logic                  rsp_tlast
);

   // Request fields.
   logic [31:0]           in_value;
   logic [1:0]            in_base_sel;
   logic                  in_upper, in_alt, in_group, in_zpad, in_left;
   logic [1:0]            in_plus;
   logic [6:0]            in_width;
   logic [6:0]            in_prec;
   logic [VALUE_BITS-1:0] in_v, in_mag;
   logic                  in_neg;
   base_type              in_base;
   logic                  accept;

   // Control and datapath registers.
   state_type             state_ff, state_in;
   base_type              base_ff, base_in;
   logic                  upper_ff, upper_in;
   logic                  alt_ff, alt_in;
   logic                  group_ff, group_in;
   logic                  left_ff, left_in;
   logic                  zfill_ff, zfill_in;
   logic                  has_sign_ff, has_sign_in;
   logic [7:0]            sign_char_ff, sign_char_in;
   logic [LEN_W-1:0]      width_ff, width_in;
   logic [CNT_W-1:0]      prec_ff, prec_in;
   digit_type             digits_ff [NUM_DIGITS];
   digit_type             digits_in [NUM_DIGITS];
   logic [ND_W-1:0]       nd_ff, nd_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  prefix_ff, prefix_in;
   logic [LEN_W-1:0]      pad_cnt_ff, pad_cnt_in;
   logic [LEN_W-1:0]      rem_ff, rem_in;
   logic [CNT_W-1:0]      idx_ff, idx_in;
   logic [1:0]            mod3_ff, mod3_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [7:0]            rsp_data_ff, rsp_data_in;
   logic                  rsp_last_ff, rsp_last_in;

   // Output side control.
   logic                  slot_free, is_emit, adv;
   logic [7:0]            emit_char;
   digit_type             cur_digit;

   // Converter.
   logic                       bcd_start, bcd_done;
   digit_type [DEC_DIGITS-1:0] bcd_digits;

   // Unpack the request word.
   assign in_value    = req_tdata[31:0];
   assign in_base_sel = req_tdata[33:32];
   assign in_upper    = req_tdata[34];
   assign in_alt      = req_tdata[35];
   assign in_group    = req_tdata[36];
   assign in_zpad     = req_tdata[37];
   assign in_left     = req_tdata[38];
   assign in_plus     = req_tdata[40:39];
   assign in_width    = req_tdata[47:41];
   assign in_prec     = req_tdata[54:48];

   // Magnitude and base of the incoming value.
   always_comb begin
      in_v   = VALUE_BITS'(in_value);
      in_neg = req_tuser & in_v[VALUE_BITS-1];
      in_mag = in_neg ? (~in_v) + VALUE_BITS'(1) : in_v;
      case (in_base_sel)
         BSEL_OCT: in_base = BASE_OCT;
         BSEL_DEC: in_base = BASE_DEC;
         default:  in_base = BASE_HEX;
      endcase
   end

   i2a_bcd u_bcd (
      .clock (clock),
      .reset (reset),
      .start (bcd_start),
      .bin   (in_mag),
      .done  (bcd_done),
      .bcd   (bcd_digits)
   );

   // Handshake and character selection.
   always_comb begin
      req_tready = (state_ff == S_IDLE);
      accept     = req_tvalid & req_tready;
      bcd_start  = accept & (in_base == BASE_DEC);
      slot_free  = ~rsp_valid_ff | rsp_tready;
      case (state_ff)
         S_PADL, S_SIGN, S_PFX0, S_PFXX, S_ZPAD, S_DIGIT, S_SEP, S_PADR: is_emit = 1'b1;
         default: is_emit = 1'b0;
      endcase
      adv = is_emit & slot_free;
      cur_digit = (idx_ff < CNT_W'(NUM_DIGITS)) ? digits_ff[idx_ff[DIG_IDX_W-1:0]] : '0;
      case (state_ff)
         S_PADL, S_PADR: emit_char = CHAR_SPACE;
         S_SIGN:         emit_char = sign_char_ff;
         S_PFXX:         emit_char = upper_ff ? CHAR_UPPER_X : CHAR_LOWER_X;
         S_DIGIT:        emit_char = digit_char(cur_digit, upper_ff);
         S_SEP:          emit_char = CHAR_APOS;
         default:        emit_char = CHAR_ZERO;
      endcase
   end

   // Sequencer: sizing steps, then the output sections in order, empty ones skipped.
   always_comb begin
      state_type after_padl, after_sign, after_pfx, after_zpad, after_digits;
      after_digits = (left_ff && pad_cnt_ff != '0) ? S_PADR : S_IDLE;
      after_zpad   = (count_ff != '0) ? S_DIGIT : after_digits;
      after_pfx    = (zfill_ff && pad_cnt_ff != '0) ? S_ZPAD : after_zpad;
      after_sign   = prefix_ff ? S_PFX0 : after_pfx;
      after_padl   = has_sign_ff ? S_SIGN : after_sign;
      state_in     = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) state_in = (in_base == BASE_DEC) ? S_CONV : S_SCAN;
         end
         S_CONV: begin
            if (bcd_done) state_in = S_SCAN;
         end
         S_SCAN:  state_in = S_SIZE;
         S_SIZE:  state_in = S_TOTAL;
         S_TOTAL: state_in = S_PLAN;
         S_PLAN: begin
            if (rem_ff == '0) begin
               state_in = S_IDLE;
            end else if (!left_ff && !zfill_ff && pad_cnt_ff != '0) begin
               state_in = S_PADL;
            end else begin
               state_in = after_padl;
            end
         end
         S_PADL: begin
            if (slot_free && pad_cnt_ff == LEN_W'(1)) state_in = after_padl;
         end
         S_SIGN: begin
            if (slot_free) state_in = after_sign;
         end
         S_PFX0: begin
            if (slot_free) state_in = S_PFXX;
         end
         S_PFXX: begin
            if (slot_free) state_in = after_pfx;
         end
         S_ZPAD: begin
            if (slot_free && pad_cnt_ff == LEN_W'(1)) state_in = after_zpad;
         end
         S_DIGIT: begin
            if (slot_free) begin
               if (idx_ff == '0) begin
                  state_in = after_digits;
               end else if (group_ff && mod3_ff == 2'd0) begin
                  state_in = S_SEP;
               end else begin
                  state_in = S_DIGIT;
               end
            end
         end
         S_SEP: begin
            if (slot_free) state_in = S_DIGIT;
         end
         S_PADR: begin
            if (slot_free && pad_cnt_ff == LEN_W'(1)) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Datapath next values.
   always_comb begin
      logic [NUM_DIGITS*3-1:0] oct_ext;
      logic [NUM_DIGITS*4-1:0] hex_ext;
      logic [CNT_W-1:0]        cmax, cm1, q_raw, q;
      logic [LEN_W-1:0]        total;
      logic [CNT_W-1:0]        r3;

      base_in      = base_ff;
      upper_in     = upper_ff;
      alt_in       = alt_ff;
      group_in     = group_ff;
      left_in      = left_ff;
      zfill_in     = zfill_ff;
      has_sign_in  = has_sign_ff;
      sign_char_in = sign_char_ff;
      width_in     = width_ff;
      prec_in      = prec_ff;
      digits_in    = digits_ff;
      nd_in        = nd_ff;
      count_in     = count_ff;
      prefix_in    = prefix_ff;
      pad_cnt_in   = pad_cnt_ff;
      rem_in       = rem_ff;
      idx_in       = idx_ff;
      mod3_in      = mod3_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;

      oct_ext = (NUM_DIGITS * 3)'(in_mag);
      hex_ext = (NUM_DIGITS * 4)'(in_mag);
      cm1     = count_ff - 1'b1;
      q_raw   = div3(cm1);
      q       = (group_ff && count_ff != '0) ? q_raw : '0;
      r3      = cm1 - CNT_W'(q_raw * CNT_W'(3));
      total   = LEN_W'(has_sign_ff) + (prefix_ff ? LEN_W'(2) : LEN_W'(0))
              + LEN_W'(count_ff) + LEN_W'(q);
      cmax    = (CNT_W'(nd_ff) > prec_ff) ? CNT_W'(nd_ff) : prec_ff;

      // Capture the options; octal and hex digits load straight away.
      if (accept) begin
         base_in  = in_base;
         upper_in = in_upper;
         alt_in   = in_alt;
         group_in = in_group;
         left_in  = in_left;
         width_in = (in_width > 7'(MAX_WIDTH)) ? 7'(MAX_WIDTH) : in_width;
         if (in_prec[6]) begin
            prec_in  = CNT_W'(1);
            zfill_in = in_zpad & ~in_left;
         end else begin
            prec_in  = (in_prec > 7'(MAX_PRECISION)) ? CNT_W'(MAX_PRECISION) : CNT_W'(in_prec);
            zfill_in = 1'b0;
         end
         has_sign_in  = req_tuser & (in_neg | in_plus != PLUS_NONE);
         if (in_neg) begin
            sign_char_in = CHAR_MINUS;
         end else if (in_plus == PLUS_SPACE) begin
            sign_char_in = CHAR_SPACE;
         end else begin
            sign_char_in = CHAR_PLUS;
         end
         for (int k = 0; k < NUM_DIGITS; k++) begin
            digits_in[k] = (in_base == BASE_OCT) ? digit_type'(oct_ext[3*k +: 3])
                                                 : hex_ext[4*k +: 4];
         end
      end

      // Decimal digits arrive from the converter.
      if (state_ff == S_CONV && bcd_done) begin
         for (int k = 0; k < DEC_DIGITS; k++) begin
            digits_in[k] = bcd_digits[k];
         end
         for (int k = DEC_DIGITS; k < NUM_DIGITS; k++) begin
            digits_in[k] = '0;
         end
      end

      // Count the significant digits.
      if (state_ff == S_SCAN) begin
         nd_in = '0;
         for (int k = 0; k < NUM_DIGITS; k++) begin
            if (digits_ff[k] != '0) nd_in = ND_W'(k + 1);
         end
      end

      // Digit count with precision and the octal leading zero, and the hex prefix.
      if (state_ff == S_SIZE) begin
         count_in = cmax;
         if (base_ff == BASE_OCT && alt_ff && (cmax == '0 || cmax == CNT_W'(nd_ff))) begin
            count_in = cmax + 1'b1;
         end
         prefix_in = (base_ff == BASE_HEX) & alt_ff & (nd_ff != '0);
      end

      // Field length, padding and the digit walk start.
      if (state_ff == S_TOTAL) begin
         pad_cnt_in = (width_ff > total) ? width_ff - total : '0;
         rem_in     = (width_ff > total) ? width_ff : total;
         idx_in     = cm1;
         mod3_in    = r3[1:0];
      end

      // One character into the output register.
      if (adv) begin
         rsp_data_in = emit_char;
         rsp_last_in = (rem_ff == LEN_W'(1));
         rem_in      = rem_ff - 1'b1;
         if (state_ff == S_PADL || state_ff == S_ZPAD || state_ff == S_PADR) begin
            pad_cnt_in = pad_cnt_ff - 1'b1;
         end
         if (state_ff == S_DIGIT && idx_ff != '0) begin
            idx_in  = idx_ff - 1'b1;
            mod3_in = (mod3_ff == 2'd0) ? 2'd2 : mod3_ff - 2'd1;
         end
      end

      rsp_valid_in = adv | (rsp_valid_ff & ~rsp_tready);
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      base_ff      <= base_in;
      upper_ff     <= upper_in;
      alt_ff       <= alt_in;
      group_ff     <= group_in;
      left_ff      <= left_in;
      zfill_ff     <= zfill_in;
      has_sign_ff  <= has_sign_in;
      sign_char_ff <= sign_char_in;
      width_ff     <= width_in;
      prec_ff      <= prec_in;
      digits_ff    <= digits_in;
      nd_ff        <= nd_in;
      count_ff     <= count_in;
      prefix_ff    <= prefix_in;
      pad_cnt_ff   <= pad_cnt_in;
      rem_ff       <= rem_in;
      idx_ff       <= idx_in;
      mod3_ff      <= mod3_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // The converter only finishes while the sequencer waits for it.
   `I2A_ASSERT_IMPL(a_conv_done_in_conv, bcd_done, state_ff == S_CONV)
   // While characters go out, some remain to be sent.
   `I2A_ASSERT_IMPL(a_rem_live, is_emit, rem_ff != '0)
   // A padding section is never entered with an empty pad count.
   `I2A_ASSERT_IMPL(a_pad_live, state_ff == S_PADL || state_ff == S_ZPAD || state_ff == S_PADR,
                    pad_cnt_ff != '0)
   // The character marked last ends the item.
   `I2A_ASSERT_NEXT(a_last_ends_item, adv && rem_ff == LEN_W'(1), state_ff == S_IDLE)

endmodule

### hw/rtl/i2a_bcd.sv
// Binary to BCD converter: one shift-and-add-3 step per cycle.
module i2a_bcd
   import i2a_pkg::*;
(
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [VALUE_BITS-1:0]          bin,
   output logic                           done,
   output digit_type [DEC_DIGITS-1:0]     bcd
);

   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic [BIT_CNT_W-1:0]       cnt_ff, cnt_in;
   logic [VALUE_BITS-1:0]      shift_ff, shift_in;
   digit_type [DEC_DIGITS-1:0] bcd_ff, bcd_in;
   digit_type [DEC_DIGITS-1:0] adj;
   logic [DEC_DIGITS*4-1:0]    adj_flat;

   // Add three to every digit of five or more, then shift in the next bit.
   always_comb begin
      for (int k = 0; k < DEC_DIGITS; k++) begin
         adj[k] = (bcd_ff[k] >= 4'd5) ? bcd_ff[k] + 4'd3 : bcd_ff[k];
      end
      adj_flat = adj;
   end

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      shift_in = shift_ff;
      bcd_in   = bcd_ff;
      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = '0;
         shift_in = bin;
         bcd_in   = '0;
      end else if (busy_ff) begin
         bcd_in   = {adj_flat[DEC_DIGITS*4-2:0], shift_ff[VALUE_BITS-1]};
         shift_in = {shift_ff[VALUE_BITS-2:0], 1'b0};
         cnt_in   = cnt_ff + 1'b1;
         if (cnt_ff == BIT_CNT_W'(VALUE_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff   <= cnt_in;
      shift_ff <= shift_in;
      bcd_ff   <= bcd_in;
   end

   assign done = done_ff;
   assign bcd  = bcd_ff;

endmodule
